// ===== hw/rtl/pgd_pkg.sv =====
package pgd_pkg;

  localparam int GAMMA_FRAC_BITS = 8;
  localparam int LOG_W = 20;
  localparam int T_W = 32;
  localparam int STEPS = 8;
  localparam int SRGB_DEN = 53805;
  localparam int SRGB_OFS = 2805;
  localparam int SRGB_MUL = 200;
  localparam int SRGB_KNEE = 10;
  localparam int SRGB_EXP_NUM = 12;
  localparam logic [24:0] DIV5_RCP = 25'd6710887;
  localparam int DIV5_SHIFT = 25;

  typedef logic [LOG_W-1:0] log_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic pow;
    logic zero;
    log_t n;
  } front_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic [T_W-1:0] t;
  } atten_t;

  function automatic log_t fx_log2(input int unsigned v_in);
    int unsigned v;
    int unsigned e;
    longint unsigned m;
    int unsigned frac;
    v = v_in & 32'hFFFF;
    if (v == 0) v = 1;
    e = 0;
    frac = 0;
    while (e < 15 && (v >> (e + 1)) != 0) e++;
    m = 64'(v) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return LOG_W'((e << 16) | frac);
  endfunction

endpackage

// ===== hw/rtl/pgd_front.sv =====
module pgd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        pixel,
  input  logic              last,
  input  logic [11:0]       gamma,
  output pgd_pkg::front_t   front_r
);

  pgd_pkg::log_t lin_tbl [256];
  pgd_pkg::log_t srgb_tbl [256];
  pgd_pkg::front_t front_nxt;

  for (genvar i = 0; i < 256; i++) begin : g_tbl
    assign lin_tbl[i] = pgd_pkg::fx_log2(i);
    assign srgb_tbl[i] = pgd_pkg::fx_log2(pgd_pkg::SRGB_MUL * i + pgd_pkg::SRGB_OFS);
  end

  always_comb begin
    front_nxt.valid = acc;
    front_nxt.last = last;
    front_nxt.pow = (gamma != 12'd0);
    if (front_nxt.pow) begin
      front_nxt.zero = (pixel == 8'd0);
      front_nxt.n = pgd_pkg::fx_log2(255) - lin_tbl[pixel];
    end else begin
      front_nxt.zero = (pixel <= 8'(pgd_pkg::SRGB_KNEE));
      front_nxt.n = pgd_pkg::fx_log2(pgd_pkg::SRGB_DEN) - srgb_tbl[pixel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else begin
      front_r.valid <= front_nxt.valid;
    end
    front_r.last <= front_nxt.last;
    front_r.pow <= front_nxt.pow;
    front_r.zero <= front_nxt.zero;
    front_r.n <= front_nxt.n;
  end

endmodule

// ===== hw/rtl/pgd_scale.sv =====
module pgd_scale #(
  parameter int GAMMA_FRAC_BITS = pgd_pkg::GAMMA_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pgd_pkg::front_t   front,
  input  logic [11:0]       gamma,
  output pgd_pkg::atten_t   atten_r
);

  logic                      valid_r;
  logic                      last_r;
  logic                      pow_r;
  logic                      zero_r;
  logic [pgd_pkg::T_W-1:0]   prod_r;
  logic [pgd_pkg::T_W-1:0]   prod_nxt;
  logic [47:0]               div_prod;
  pgd_pkg::atten_t           atten_nxt;

  always_comb begin
    if (front.pow) begin
      prod_nxt = pgd_pkg::T_W'(front.n) * pgd_pkg::T_W'(gamma);
    end else begin
      prod_nxt = pgd_pkg::T_W'(front.n) * pgd_pkg::T_W'(pgd_pkg::SRGB_EXP_NUM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= front.valid;
    end
    last_r <= front.last;
    pow_r <= front.pow;
    zero_r <= front.zero;
    prod_r <= prod_nxt;
  end

  assign div_prod = 48'(prod_r[22:0]) * 48'(pgd_pkg::DIV5_RCP);

  always_comb begin
    atten_nxt.valid = valid_r;
    atten_nxt.last = last_r;
    if (zero_r) begin
      atten_nxt.t = '1;
    end else if (pow_r) begin
      atten_nxt.t = prod_r >> GAMMA_FRAC_BITS;
    end else begin
      atten_nxt.t = pgd_pkg::T_W'(div_prod >> pgd_pkg::DIV5_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atten_r.valid <= 1'b0;
    end else begin
      atten_r.valid <= atten_nxt.valid;
    end
    atten_r.last <= atten_nxt.last;
    atten_r.t <= atten_nxt.t;
  end

endmodule

// ===== hw/rtl/pgd_search.sv =====
module pgd_search (
  input  logic              clk,
  input  logic              rst_n,
  input  pgd_pkg::atten_t   atten,
  output logic              valid_o,
  output logic [7:0]        code_o,
  output logic              last_o
);

  localparam int S = pgd_pkg::STEPS;

  pgd_pkg::log_t           lg_tbl [256];
  logic                    valid_r [S];
  logic                    last_r [S];
  logic [7:0]              k_r [S];
  logic [pgd_pkg::T_W-1:0] t_r [S];

  for (genvar i = 0; i < 256; i++) begin : g_tbl
    assign lg_tbl[i] = pgd_pkg::fx_log2(i);
  end

  for (genvar j = 0; j < S; j++) begin : g_step
    logic                    v_in;
    logic                    l_in;
    logic [7:0]              k_in;
    logic [pgd_pkg::T_W-1:0] t_in;
    logic [7:0]              cand;
    pgd_pkg::log_t           n;

    if (j == 0) begin : g_first
      assign v_in = atten.valid;
      assign l_in = atten.last;
      assign k_in = 8'd0;
      assign t_in = atten.t;
    end else begin : g_next
      assign v_in = valid_r[j-1];
      assign l_in = last_r[j-1];
      assign k_in = k_r[j-1];
      assign t_in = t_r[j-1];
    end

    assign cand = k_in | (8'd128 >> j);
    assign n = pgd_pkg::fx_log2(255) - lg_tbl[cand];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else begin
        valid_r[j] <= v_in;
      end
      last_r[j] <= l_in;
      t_r[j] <= t_in;
      k_r[j] <= (pgd_pkg::T_W'(n) >= t_in) ? cand : k_in;
    end
  end

  assign valid_o = valid_r[S-1];
  assign code_o = k_r[S-1];
  assign last_o = last_r[S-1];

endmodule

// ===== hw/rtl/pixel_gamma_decode.sv =====
// Gamma decode of 8-bit pixel codes, one word per clock.
// Input: a word is taken at each rising edge with start high and busy low.
// busy is always low, so a new word may be offered in every cycle.
// Output: out_valid marks a decoded word for exactly one cycle; there is
// no back-pressure, the receiver must take it in that cycle.
// Pipeline: each word passes through one log lookup stage, one
// multiply stage, one scaling stage and eight binary-search stages that
// stand in for exp2. Throughput is one word per cycle.
// cfg_gamma_value holds the exponent with GAMMA_FRAC_BITS fraction bits;
// zero selects the sRGB curve. Write it only while the pipeline is empty.
// Synchronous reset empties the pipeline and clears the exponent to zero.
module pixel_gamma_decode #(
  parameter int GAMMA_FRAC_BITS = pgd_pkg::GAMMA_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_pixel_in,
  input  logic        in_last_in,
  input  logic        cfg_we,
  input  logic [11:0] cfg_gamma_value,
  output logic        out_valid,
  output logic [7:0]  out_pixel_out,
  output logic        out_last_out
);

  logic [11:0]      gamma_r;
  logic             acc;
  pgd_pkg::front_t  front;
  pgd_pkg::atten_t  atten;

  assign busy = 1'b0;
  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= 12'd0;
    end else if (cfg_we) begin
      gamma_r <= cfg_gamma_value;
    end
  end

  pgd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .pixel   (in_pixel_in),
    .last    (in_last_in),
    .gamma   (gamma_r),
    .front_r (front)
  );

  pgd_scale #(
    .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .front   (front),
    .gamma   (gamma_r),
    .atten_r (atten)
  );

  pgd_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .atten   (atten),
    .valid_o (out_valid),
    .code_o  (out_pixel_out),
    .last_o  (out_last_out)
  );

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 11))
    else $error("word out without accept");
  a_last_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_out == $past(in_last_in, 11))
    else $error("last flag mismatch");
  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_pixel_in == 8'd0, 11) |-> out_pixel_out == 8'd0)
    else $error("zero code not zero");
  a_full_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_pixel_in == 8'd255, 11) |-> out_pixel_out == 8'd255)
    else $error("full code not full");

endmodule
